### rtl/core/eanupc_pkg.sv
`default_nettype none
package eanupc_pkg;

  typedef enum logic [1:0] {
    CODE_EAN13 = 2'd0,
    CODE_EAN8  = 2'd1,
    CODE_UPCA  = 2'd2,
    CODE_UPCE  = 2'd3
  } code_type_t;

  localparam int unsigned NUM_DIGITS  = 13;
  localparam int unsigned DIGITS_W    = 4 * NUM_DIGITS;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [6:0] GUARD_SIDE     = 7'h05;
  localparam logic [6:0] GUARD_MID      = 7'h0A;
  localparam logic [6:0] GUARD_UPCE_END = 7'h15;
  localparam logic [2:0] CNT_SIDE       = 3'd3;
  localparam logic [2:0] CNT_MID        = 3'd5;
  localparam logic [2:0] CNT_UPCE_END   = 3'd6;
  localparam logic [2:0] CNT_DIGIT      = 3'd7;

  // Index of the final segment for each symbology
  localparam logic [3:0] LAST_EAN13 = 4'd14;
  localparam logic [3:0] LAST_EAN8  = 4'd10;
  localparam logic [3:0] LAST_UPCA  = 4'd14;
  localparam logic [3:0] LAST_UPCE  = 4'd7;

  // Classified item as it waits between front and back
  typedef struct packed {
    code_type_t          code_type;
    logic [DIGITS_W-1:0] digits;
    logic [5:0]          parity;   // bit 5 for the first left digit, 1 = G code
    logic                bad;
  } desc_t;

  function automatic logic [3:0] digit_at(input logic [DIGITS_W-1:0] v, input logic [3:0] k);
    logic [3:0] d;
    d = 4'd0;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (k == 4'(i)) d = v[DIGITS_W-1-4*i -: 4];
    end
    return d;
  endfunction

  function automatic logic [6:0] code_l(input logic [3:0] d);
    logic [6:0] c;
    case (d)
      4'd0:    c = 7'h0D;
      4'd1:    c = 7'h19;
      4'd2:    c = 7'h13;
      4'd3:    c = 7'h3D;
      4'd4:    c = 7'h23;
      4'd5:    c = 7'h31;
      4'd6:    c = 7'h2F;
      4'd7:    c = 7'h3B;
      4'd8:    c = 7'h37;
      4'd9:    c = 7'h0B;
      default: c = 7'h00;
    endcase
    return c;
  endfunction

  function automatic logic [6:0] code_g(input logic [3:0] d);
    logic [6:0] c;
    case (d)
      4'd0:    c = 7'h27;
      4'd1:    c = 7'h33;
      4'd2:    c = 7'h1B;
      4'd3:    c = 7'h21;
      4'd4:    c = 7'h1D;
      4'd5:    c = 7'h39;
      4'd6:    c = 7'h05;
      4'd7:    c = 7'h11;
      4'd8:    c = 7'h09;
      4'd9:    c = 7'h17;
      default: c = 7'h00;
    endcase
    return c;
  endfunction

  function automatic logic [5:0] ean13_parity(input logic [3:0] d);
    logic [5:0] p;
    case (d)
      4'd0:    p = 6'h00;
      4'd1:    p = 6'h0B;
      4'd2:    p = 6'h0D;
      4'd3:    p = 6'h0E;
      4'd4:    p = 6'h13;
      4'd5:    p = 6'h19;
      4'd6:    p = 6'h1C;
      4'd7:    p = 6'h15;
      4'd8:    p = 6'h16;
      4'd9:    p = 6'h1A;
      default: p = 6'h00;
    endcase
    return p;
  endfunction

  function automatic logic [5:0] upce_parity(input logic [3:0] d);
    logic [5:0] p;
    case (d)
      4'd0:    p = 6'h38;
      4'd1:    p = 6'h34;
      4'd2:    p = 6'h32;
      4'd3:    p = 6'h31;
      4'd4:    p = 6'h2C;
      4'd5:    p = 6'h26;
      4'd6:    p = 6'h23;
      4'd7:    p = 6'h2A;
      4'd8:    p = 6'h29;
      4'd9:    p = 6'h25;
      default: p = 6'h00;
    endcase
    return p;
  endfunction

  function automatic logic [3:0] used_digits(input code_type_t t);
    logic [3:0] n;
    case (t)
      CODE_EAN13: n = 4'd13;
      CODE_EAN8:  n = 4'd8;
      CODE_UPCA:  n = 4'd12;
      CODE_UPCE:  n = 4'd8;
      default:    n = 4'd13;
    endcase
    return n;
  endfunction

endpackage
`default_nettype wire

### rtl/core/eanupc_front.sv
`default_nettype none
// Classifies an incoming item: digit range check and L/G parity pattern.
module eanupc_front (
  input  wire logic [1:0]                     code_type,
  input  wire logic [eanupc_pkg::DIGITS_W-1:0] digits_bcd,
  output eanupc_pkg::desc_t                   desc
);

  eanupc_pkg::code_type_t ctype;
  logic [3:0]             used;
  logic                   bad;
  logic [3:0]             d0;
  logic [5:0]             par;

  assign ctype = eanupc_pkg::code_type_t'(code_type);
  assign used  = eanupc_pkg::used_digits(ctype);
  assign d0    = eanupc_pkg::digit_at(digits_bcd, 4'd0);

  always_comb begin
    bad = 1'b0;
    for (int i = 0; i < eanupc_pkg::NUM_DIGITS; i++) begin
      if ((4'(i) < used) &&
          (digits_bcd[eanupc_pkg::DIGITS_W-1-4*i -: 4] > 4'd9)) bad = 1'b1;
    end
  end

  always_comb begin
    case (ctype)
      eanupc_pkg::CODE_EAN13: par = eanupc_pkg::ean13_parity(d0);
      eanupc_pkg::CODE_UPCE: begin
        // nonzero number system flips the pattern
        par = eanupc_pkg::upce_parity(eanupc_pkg::digit_at(digits_bcd, 4'd7))
              ^ {6{d0 != 4'd0}};
      end
      default: par = 6'h00;
    endcase
  end

  always_comb begin
    desc.code_type = ctype;
    desc.digits    = digits_bcd;
    desc.parity    = par;
    desc.bad       = bad;
  end

endmodule
`default_nettype wire

### rtl/core/eanupc_queue.sv
`default_nettype none
// Small FIFO of classified items between front and back.
module eanupc_queue #(
  parameter int unsigned DEPTH = eanupc_pkg::QUEUE_DEPTH
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  eanupc_pkg::desc_t  push_data,
  output logic               full,
  input  wire logic          pop,
  output logic               not_empty,
  output eanupc_pkg::desc_t  head
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  eanupc_pkg::desc_t mem [DEPTH];
  logic [PtrW-1:0]   wr_ptr;
  logic [PtrW-1:0]   rd_ptr;
  logic [CntW-1:0]   count;
  logic              do_push;
  logic              do_pop;

  assign full      = (count == CntW'(DEPTH));
  assign not_empty = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign head      = mem[rd_ptr];

  function automatic logic [PtrW-1:0] wrap_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wrap_inc(wr_ptr);
      if (do_pop)  rd_ptr <= wrap_inc(rd_ptr);
      if (do_push && !do_pop)      count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

endmodule
`default_nettype wire

### rtl/core/eanupc_back.sv
`default_nettype none
// Segment sequencer: queue head to output register, one segment per cycle unless stalled.
module eanupc_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          head_valid,
  input  eanupc_pkg::desc_t  head,
  output logic               pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [6:0]         module_bits,
  output logic [2:0]         module_count,
  output logic               long_bars,
  output logic               is_guard,
  output logic [3:0]         encoded_digit,
  output logic               last_segment,
  output logic               bad_digit
);

  logic [3:0] seg;
  logic [3:0] seg_next;
  logic       advance;
  logic       emit;

  logic [6:0] s_bits;
  logic [2:0] s_cnt;
  logic       s_long;
  logic       s_guard;
  logic [3:0] s_dig;
  logic       s_last;

  logic [3:0] last_idx;
  logic       is_left;
  logic       is_right;
  logic       is_mid;
  logic [3:0] k;
  logic [3:0] d;
  logic       use_g;

  assign advance = !out_valid || out_ready;
  assign emit    = advance && head_valid;
  assign pop     = emit && s_last;

  always_comb begin
    last_idx = eanupc_pkg::LAST_EAN13;
    is_left  = 1'b0;
    is_right = 1'b0;
    is_mid   = 1'b0;
    k        = 4'd0;
    case (head.code_type)
      eanupc_pkg::CODE_EAN13: begin
        last_idx = eanupc_pkg::LAST_EAN13;
        is_left  = (seg >= 4'd1) && (seg <= 4'd6);
        is_mid   = (seg == 4'd7);
        is_right = (seg >= 4'd8) && (seg <= 4'd13);
        k        = is_left ? seg : seg - 4'd1;
      end
      eanupc_pkg::CODE_EAN8: begin
        last_idx = eanupc_pkg::LAST_EAN8;
        is_left  = (seg >= 4'd1) && (seg <= 4'd4);
        is_mid   = (seg == 4'd5);
        is_right = (seg >= 4'd6) && (seg <= 4'd9);
        k        = is_left ? seg - 4'd1 : seg - 4'd2;
      end
      eanupc_pkg::CODE_UPCA: begin
        last_idx = eanupc_pkg::LAST_UPCA;
        is_left  = (seg >= 4'd1) && (seg <= 4'd6);
        is_mid   = (seg == 4'd7);
        is_right = (seg >= 4'd8) && (seg <= 4'd13);
        k        = is_left ? seg - 4'd1 : seg - 4'd2;
      end
      eanupc_pkg::CODE_UPCE: begin
        last_idx = eanupc_pkg::LAST_UPCE;
        is_left  = (seg >= 4'd1) && (seg <= 4'd6);
        k        = seg;
      end
      default: ;
    endcase
  end

  assign d     = eanupc_pkg::digit_at(head.digits, k);
  assign use_g = is_left && head.parity[3'(4'd6 - seg)];

  always_comb begin
    s_bits  = eanupc_pkg::GUARD_SIDE;
    s_cnt   = eanupc_pkg::CNT_SIDE;
    s_long  = 1'b1;
    s_guard = 1'b1;
    s_dig   = 4'd0;
    s_last  = (seg == last_idx);
    if (head.bad) begin
      s_bits  = 7'h00;
      s_cnt   = 3'd0;
      s_long  = 1'b0;
      s_guard = 1'b0;
      s_last  = 1'b1;
    end else if (is_left || is_right) begin
      s_bits  = is_right ? ~eanupc_pkg::code_l(d) :
                use_g    ? eanupc_pkg::code_g(d) : eanupc_pkg::code_l(d);
      s_cnt   = eanupc_pkg::CNT_DIGIT;
      s_guard = 1'b0;
      s_dig   = d;
      // UPC-A outer digits are drawn long
      s_long  = (head.code_type == eanupc_pkg::CODE_UPCA) &&
                ((is_left && seg == 4'd1) || (is_right && seg == 4'd13));
    end else if (is_mid) begin
      s_bits = eanupc_pkg::GUARD_MID;
      s_cnt  = eanupc_pkg::CNT_MID;
    end else if (s_last && head.code_type == eanupc_pkg::CODE_UPCE) begin
      s_bits = eanupc_pkg::GUARD_UPCE_END;
      s_cnt  = eanupc_pkg::CNT_UPCE_END;
    end
  end

  always_comb begin
    seg_next = seg;
    if (emit) seg_next = s_last ? 4'd0 : seg + 4'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seg       <= 4'd0;
      out_valid <= 1'b0;
    end else begin
      seg <= seg_next;
      if (advance) out_valid <= head_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      module_bits   <= s_bits;
      module_count  <= s_cnt;
      long_bars     <= s_long;
      is_guard      <= s_guard;
      encoded_digit <= s_dig;
      last_segment  <= s_last;
      bad_digit     <= head.bad;
    end
  end

endmodule
`default_nettype wire

### rtl/core/ean_upc_module_pattern_encoder_top.sv
`default_nettype none
// EAN-13 / EAN-8 / UPC-A / UPC-E module pattern encoder. Each accepted item (symbology plus
// packed BCD digits) produces one result per bar segment, guards included, in drawing order:
// 15 results for EAN-13 and UPC-A, 11 for EAN-8, 8 for UPC-E, or a single error result when
// a used digit is above 9. The back-end sequencer emits one segment per cycle unless out_ready
// stalls it; successive items run back to back with no gap. The front classifies an item in
// the cycle it is accepted and parks it in a QUEUE_DEPTH-entry queue, so input is taken while
// earlier items are still being emitted.
module ean_upc_module_pattern_encoder_top #(
  parameter int unsigned QUEUE_DEPTH = eanupc_pkg::QUEUE_DEPTH
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [1:0]                      code_type,
  input  wire logic [eanupc_pkg::DIGITS_W-1:0] digits_bcd,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [6:0]                           module_bits,
  output logic [2:0]                           module_count,
  output logic                                 long_bars,
  output logic                                 is_guard,
  output logic [3:0]                           encoded_digit,
  output logic                                 last_segment,
  output logic                                 bad_digit
);

  eanupc_pkg::desc_t in_desc;
  eanupc_pkg::desc_t head;
  logic              q_full;
  logic              q_valid;
  logic              pop;

  assign in_ready = !q_full;

  eanupc_front u_front (
    .code_type  (code_type),
    .digits_bcd (digits_bcd),
    .desc       (in_desc)
  );

  eanupc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (in_valid),
    .push_data (in_desc),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_valid),
    .head      (head)
  );

  eanupc_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head_valid    (q_valid),
    .head          (head),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .module_bits   (module_bits),
    .module_count  (module_count),
    .long_bars     (long_bars),
    .is_guard      (is_guard),
    .encoded_digit (encoded_digit),
    .last_segment  (last_segment),
    .bad_digit     (bad_digit)
  );

endmodule
`default_nettype wire

### rtl/core/eanupc_checker.sv
`default_nettype none
module eanupc_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [6:0] module_bits,
  input wire logic [2:0] module_count,
  input wire logic       long_bars,
  input wire logic       is_guard,
  input wire logic [3:0] encoded_digit,
  input wire logic       last_segment,
  input wire logic       bad_digit
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(module_bits) && $stable(last_segment))
    else $error("output item changed while stalled");

  a_bad_alone: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_digit |-> last_segment && module_count == 3'd0 && module_bits == 7'h00)
    else $error("error result malformed");

  a_guard_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_guard |-> long_bars && encoded_digit == 4'd0 && !bad_digit)
    else $error("guard segment fields wrong");

  a_count_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid && !bad_digit |-> module_count == 3'd3 || module_count == 3'd5 ||
                                module_count == 3'd6 || module_count == 3'd7)
    else $error("illegal module count");

  a_digit_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_guard && !bad_digit |-> encoded_digit <= 4'd9 && module_count == 3'd7)
    else $error("digit segment malformed");

endmodule

bind ean_upc_module_pattern_encoder_top eanupc_checker u_checker (.*);
`default_nettype wire

### sim/ean_upc_module_pattern_encoder_top_test.sv
`timescale 1ns / 1ps

module ean_upc_module_pattern_encoder_top_test;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned LONG_HOLD   = 60;
  localparam int unsigned DRAIN_LIMIT = 5000;
  localparam int unsigned SETTLE      = 30;

  typedef struct packed {
    logic [6:0] bits;
    logic [2:0] count;
    logic       longb;
    logic       guard;
    logic [3:0] digit;
    logic       last;
    logic       bad;
  } segment_t;

  logic                            clk;
  logic                            rst = 1'b1;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  logic [1:0]                      code_type = 2'd0;
  logic [eanupc_pkg::DIGITS_W-1:0] digits_bcd = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic [6:0]                      module_bits;
  logic [2:0]                      module_count;
  logic                            long_bars;
  logic                            is_guard;
  logic [3:0]                      encoded_digit;
  logic                            last_segment;
  logic                            bad_digit;

  segment_t    segments_due[$];
  segment_t    seg_want;
  int unsigned cycle_count = 0;
  int unsigned mismatches = 0;
  int unsigned segments_checked = 0;
  int unsigned codes_sent = 0;
  int unsigned bad_codes = 0;
  int unsigned type_count[4] = '{0, 0, 0, 0};
  bit          gaps_on = 1'b1;
  bit          stalls_on = 1'b1;
  int unsigned hold_asked = 0;
  int unsigned hold_done = 0;
  int unsigned ready_hold_left = 0;

  ean_upc_module_pattern_encoder_top i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .code_type     (code_type),
    .digits_bcd    (digits_bcd),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .module_bits   (module_bits),
    .module_count  (module_count),
    .long_bars     (long_bars),
    .is_guard      (is_guard),
    .encoded_digit (encoded_digit),
    .last_segment  (last_segment),
    .bad_digit     (bad_digit)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 40) $display("MISMATCH cycle %0d: %s", cycle_count, msg);
  endtask

  // ---------------- expected segment stream ----------------

  function automatic void push_segment(input logic [6:0] bits, input logic [2:0] cnt,
                                       input logic longb, input logic guard,
                                       input logic [3:0] digit, input logic last);
    segments_due.push_back({bits, cnt, longb, guard, digit, last, 1'b0});
  endfunction

  function automatic void push_digit(input logic [3:0] dg, input logic use_g,
                                     input logic right_half, input logic longb);
    logic [6:0] l, r, pat;
    case (dg)
      4'd0:    l = 7'h0D;
      4'd1:    l = 7'h19;
      4'd2:    l = 7'h13;
      4'd3:    l = 7'h3D;
      4'd4:    l = 7'h23;
      4'd5:    l = 7'h31;
      4'd6:    l = 7'h2F;
      4'd7:    l = 7'h3B;
      4'd8:    l = 7'h37;
      default: l = 7'h0B;
    endcase
    r = ~l;
    if (right_half) begin
      pat = r;
    end else if (use_g) begin
      // G code is the R code drawn mirrored
      for (int i = 0; i < 7; i++) pat[i] = r[6-i];
    end else begin
      pat = l;
    end
    push_segment(pat, eanupc_pkg::CNT_DIGIT, longb, 1'b0, dg, 1'b0);
  endfunction

  function automatic void encode_symbol(input eanupc_pkg::code_type_t t,
                                        input logic [eanupc_pkg::DIGITS_W-1:0] d);
    logic [3:0]  dg [13];
    logic [5:0]  par;
    logic        bad;
    int unsigned n_used;
    codes_sent++;
    type_count[t]++;
    for (int k = 0; k < 13; k++) dg[k] = d[eanupc_pkg::DIGITS_W-1-4*k -: 4];
    n_used = (t == eanupc_pkg::CODE_EAN13) ? 13 : (t == eanupc_pkg::CODE_UPCA) ? 12 : 8;
    bad = 1'b0;
    for (int k = 0; k < n_used; k++) begin
      if (dg[k] > 4'd9) bad = 1'b1;
    end
    if (bad) begin
      bad_codes++;
      segments_due.push_back({7'd0, 3'd0, 1'b0, 1'b0, 4'd0, 1'b1, 1'b1});
      return;
    end
    push_segment(eanupc_pkg::GUARD_SIDE, eanupc_pkg::CNT_SIDE, 1'b1, 1'b1, 4'd0, 1'b0);
    case (t)
      eanupc_pkg::CODE_EAN13: begin
        case (dg[0])
          4'd0:    par = 6'h00;
          4'd1:    par = 6'h0B;
          4'd2:    par = 6'h0D;
          4'd3:    par = 6'h0E;
          4'd4:    par = 6'h13;
          4'd5:    par = 6'h19;
          4'd6:    par = 6'h1C;
          4'd7:    par = 6'h15;
          4'd8:    par = 6'h16;
          default: par = 6'h1A;
        endcase
        for (int k = 1; k <= 6; k++) push_digit(dg[k], par[6-k], 1'b0, 1'b0);
        push_segment(eanupc_pkg::GUARD_MID, eanupc_pkg::CNT_MID, 1'b1, 1'b1, 4'd0, 1'b0);
        for (int k = 7; k <= 12; k++) push_digit(dg[k], 1'b0, 1'b1, 1'b0);
        push_segment(eanupc_pkg::GUARD_SIDE, eanupc_pkg::CNT_SIDE, 1'b1, 1'b1, 4'd0, 1'b1);
      end
      eanupc_pkg::CODE_EAN8: begin
        for (int k = 0; k <= 3; k++) push_digit(dg[k], 1'b0, 1'b0, 1'b0);
        push_segment(eanupc_pkg::GUARD_MID, eanupc_pkg::CNT_MID, 1'b1, 1'b1, 4'd0, 1'b0);
        for (int k = 4; k <= 7; k++) push_digit(dg[k], 1'b0, 1'b1, 1'b0);
        push_segment(eanupc_pkg::GUARD_SIDE, eanupc_pkg::CNT_SIDE, 1'b1, 1'b1, 4'd0, 1'b1);
      end
      eanupc_pkg::CODE_UPCA: begin
        push_digit(dg[0], 1'b0, 1'b0, 1'b1);
        for (int k = 1; k <= 5; k++) push_digit(dg[k], 1'b0, 1'b0, 1'b0);
        push_segment(eanupc_pkg::GUARD_MID, eanupc_pkg::CNT_MID, 1'b1, 1'b1, 4'd0, 1'b0);
        for (int k = 6; k <= 10; k++) push_digit(dg[k], 1'b0, 1'b1, 1'b0);
        push_digit(dg[11], 1'b0, 1'b1, 1'b1);
        push_segment(eanupc_pkg::GUARD_SIDE, eanupc_pkg::CNT_SIDE, 1'b1, 1'b1, 4'd0, 1'b1);
      end
      default: begin
        case (dg[7])
          4'd0:    par = 6'h38;
          4'd1:    par = 6'h34;
          4'd2:    par = 6'h32;
          4'd3:    par = 6'h31;
          4'd4:    par = 6'h2C;
          4'd5:    par = 6'h26;
          4'd6:    par = 6'h23;
          4'd7:    par = 6'h2A;
          4'd8:    par = 6'h29;
          default: par = 6'h25;
        endcase
        if (dg[0] != 4'd0) par = ~par;
        for (int k = 1; k <= 6; k++) push_digit(dg[k], par[6-k], 1'b0, 1'b0);
        push_segment(eanupc_pkg::GUARD_UPCE_END, eanupc_pkg::CNT_UPCE_END,
                     1'b1, 1'b1, 4'd0, 1'b1);
      end
    endcase
  endfunction

  // ---------------- result side ----------------

  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_done != hold_asked) begin
      hold_done = hold_asked;
      ready_hold_left = LONG_HOLD - 1;
      out_ready <= 1'b0;
    end else if (ready_hold_left != 0) begin
      ready_hold_left--;
      out_ready <= 1'b0;
    end else if (stalls_on && $urandom_range(0, 7) == 0) begin
      ready_hold_left = $urandom_range(1, 6) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (segments_due.size() == 0) begin
        report_mismatch($sformatf("unexpected segment bits=%h count=%0d bad=%b",
                                  module_bits, module_count, bad_digit));
      end else begin
        seg_want = segments_due.pop_front();
        segments_checked++;
        if (module_bits !== seg_want.bits)
          report_mismatch($sformatf("module_bits %h, want %h", module_bits, seg_want.bits));
        if (module_count !== seg_want.count)
          report_mismatch($sformatf("module_count %0d, want %0d", module_count,
                                    seg_want.count));
        if (long_bars !== seg_want.longb)
          report_mismatch($sformatf("long_bars %b, want %b", long_bars, seg_want.longb));
        if (is_guard !== seg_want.guard)
          report_mismatch($sformatf("is_guard %b, want %b", is_guard, seg_want.guard));
        if (encoded_digit !== seg_want.digit)
          report_mismatch($sformatf("encoded_digit %0d, want %0d", encoded_digit,
                                    seg_want.digit));
        if (last_segment !== seg_want.last)
          report_mismatch($sformatf("last_segment %b, want %b", last_segment, seg_want.last));
        if (bad_digit !== seg_want.bad)
          report_mismatch($sformatf("bad_digit %b, want %b", bad_digit, seg_want.bad));
      end
    end
  end

  // ---------------- input side ----------------

  // called at a falling edge; returns at a falling edge with valid still high
  task automatic send_code(input eanupc_pkg::code_type_t t,
                           input logic [eanupc_pkg::DIGITS_W-1:0] d);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_valid   <= 1'b1;
    code_type  <= t;
    digits_bcd <= d;
    do @(posedge clk); while (!in_ready);
    encode_symbol(t, d);
    @(negedge clk);
  endtask

  task automatic stop_input();
    in_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_results_done();
    int unsigned waited;
    waited = 0;
    while (segments_due.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    if (segments_due.size() != 0) begin
      report_mismatch($sformatf("%0d expected segments never arrived", segments_due.size()));
      segments_due.delete();
    end
  endtask

  function automatic logic [eanupc_pkg::DIGITS_W-1:0] valid_digits();
    logic [eanupc_pkg::DIGITS_W-1:0] v;
    for (int k = 0; k < eanupc_pkg::NUM_DIGITS; k++)
      v[eanupc_pkg::DIGITS_W-1-4*k -: 4] = 4'($urandom_range(0, 9));
    return v;
  endfunction

  task automatic send_random_code();
    eanupc_pkg::code_type_t          t;
    logic [eanupc_pkg::DIGITS_W-1:0] d;
    int unsigned                     pick, n_used, pos;
    t = eanupc_pkg::code_type_t'($urandom_range(0, 3));
    n_used = (t == eanupc_pkg::CODE_EAN13) ? 13 : (t == eanupc_pkg::CODE_UPCA) ? 12 : 8;
    pick = $urandom_range(0, 99);
    d = valid_digits();
    if (pick < 15) begin
      d = eanupc_pkg::DIGITS_W'({$urandom, $urandom});
    end else if (pick < 30) begin
      pos = $urandom_range(0, n_used - 1);
      d[eanupc_pkg::DIGITS_W-1-4*pos -: 4] = 4'($urandom_range(10, 15));
    end else if (pick < 65) begin
      // trailing digits past the symbol length must not matter
      for (int k = n_used; k < eanupc_pkg::NUM_DIGITS; k++)
        d[eanupc_pkg::DIGITS_W-1-4*k -: 4] = 4'($urandom_range(0, 15));
    end
    send_code(t, d);
  endtask

  // ---------------- tests ----------------

  task automatic test_directed_codes();
    logic [eanupc_pkg::DIGITS_W-1:0] d;
    // leading digit selects the L/G mix of the EAN-13 left half
    for (int i = 0; i < 10; i++) begin
      d = valid_digits();
      d[51:48] = 4'(i);
      send_code(eanupc_pkg::CODE_EAN13, d);
    end
    // UPC-E: digit 7 selects the mix, any nonzero number system inverts it
    for (int i = 0; i < 10; i++) begin
      d = valid_digits();
      d[51:48] = (i % 3 == 0) ? 4'd0 : (i % 3 == 1) ? 4'd1 : 4'(i);
      d[23:20] = 4'(i);
      send_code(eanupc_pkg::CODE_UPCE, d);
    end
    send_code(eanupc_pkg::CODE_EAN8, '0);
    send_code(eanupc_pkg::CODE_UPCA, 52'h9999_9999_9999_F);
    send_code(eanupc_pkg::CODE_EAN13, '1);
    send_code(eanupc_pkg::CODE_EAN8, 52'h1234_567A_0000_0);
    send_code(eanupc_pkg::CODE_UPCA, 52'h0000_0000_000F_0);
    send_code(eanupc_pkg::CODE_UPCE, 52'hB000_0000_0000_0);
    stop_input();
  endtask

  task automatic test_random_codes(input int unsigned n);
    for (int i = 0; i < n; i++) begin
      if (i % 10 == 0) begin
        gaps_on   = ($urandom_range(0, 2) != 0);
        stalls_on = ($urandom_range(0, 2) != 0);
      end
      send_random_code();
    end
    stop_input();
  endtask

  // receiver goes quiet while items keep coming, so the input must back up
  task automatic test_output_backpressure();
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    hold_asked++;
    for (int i = 0; i < 8; i++) send_random_code();
    stop_input();
  endtask

  task automatic test_drain_pause();
    for (int i = 0; i < 3; i++) send_random_code();
    stop_input();
    wait_results_done();
    for (int i = 0; i < 5; i++) send_random_code();
    stop_input();
  endtask

  task automatic test_streaming();
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    for (int i = 0; i < 15; i++) send_random_code();
    stop_input();
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    test_directed_codes();
    test_random_codes(35);
    test_output_backpressure();
    test_drain_pause();
    test_random_codes(30);
    test_streaming();
    wait_results_done();
    repeat (SETTLE) @(posedge clk);
    $display("ran %0d codes (%0d rejected for a bad digit), checked %0d segments",
             codes_sent, bad_codes, segments_checked);
    $display("per symbology: EAN-13 %0d, EAN-8 %0d, UPC-A %0d, UPC-E %0d; %0d mismatches",
             type_count[0], type_count[1], type_count[2], type_count[3], mismatches);
    if (mismatches == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

### filelist.f
rtl/core/eanupc_pkg.sv
rtl/core/eanupc_front.sv
rtl/core/eanupc_queue.sv
rtl/core/eanupc_back.sv
rtl/core/ean_upc_module_pattern_encoder_top.sv
rtl/core/eanupc_checker.sv
sim/ean_upc_module_pattern_encoder_top_test.sv
